// ===== sv/cartesian_to_polar_unit_defines.svh =====
// Assertion macros for the checker file of the polar conversion block.
`ifndef CARTESIAN_TO_POLAR_UNIT_DEFINES_SVH
`define CARTESIAN_TO_POLAR_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is applied.
`define C2P_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c2p checker: implication violated");

// Next-cycle implication, ignored while reset is applied.
`define C2P_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c2p checker: next-cycle implication violated");

// Next-cycle implication that is also checked across reset.
`define C2P_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("c2p checker: reset behavior violated");

`endif

// ===== sv/c2p_pkg.sv =====
// Shared widths, stage indexes, register codes and the arctangent table.
package c2p_pkg;

  localparam int COORD_BITS    = 12;
  localparam int CENTER_W      = COORD_BITS - 1;
  localparam int DELTA_W       = COORD_BITS + 1;
  localparam int MAG_W         = COORD_BITS;
  localparam int DZ_W          = 4;
  localparam int CFG_W         = CENTER_W;
  localparam int CFG_IDX_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X  = 2'd0,
    REG_CENTER_Y  = 2'd1,
    REG_DEAD_ZONE = 2'd2
  } cfg_reg_t;

  // CORDIC datapath.
  localparam int CORDIC_STAGES = 16;
  localparam int CORDIC_FRAC   = 24;
  localparam int XY_W          = MAG_W + 3 + CORDIC_FRAC;
  localparam int Z_W           = CORDIC_FRAC + 3;
  localparam int ANG_W         = 15;
  localparam int ANG_SHIFT     = CORDIC_FRAC - 12;
  localparam int ROUND_BIAS    = 1 << (CORDIC_FRAC - 13);

  localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(12868);
  localparam logic signed [ANG_W-1:0] ANG_NEG_PI  = ANG_W'(-12868);
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(6434);

  // Square root datapath.
  localparam int SQ_W       = 2 * MAG_W + 1;
  localparam int RAD_W      = SQ_W + 8;
  localparam int ROOT_W     = (RAD_W + 1) / 2;
  localparam int RAD_PAD_W  = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int DIST_W     = 17;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Pipeline stage indexes.
  localparam int S_PREP     = 0;
  localparam int S_SQR      = S_PREP + 1;
  localparam int S_SUM      = S_SQR + 1;
  localparam int SQRT_LAST  = S_SUM + ROOT_W;
  localparam int S_ANG      = S_PREP + CORDIC_STAGES + 1;
  localparam int PIPE_DEPTH = ((S_ANG > SQRT_LAST) ? S_ANG : SQRT_LAST) + 1;

  // atan(2^-i) in Q.24, rounded to nearest.
  function automatic logic signed [Z_W-1:0] atan_q24(input int idx);
    logic signed [Z_W-1:0] val;
    case (idx)
      0:       val = Z_W'(13176795);
      1:       val = Z_W'(7778716);
      2:       val = Z_W'(4110060);
      3:       val = Z_W'(2086331);
      4:       val = Z_W'(1047214);
      5:       val = Z_W'(524117);
      6:       val = Z_W'(262123);
      7:       val = Z_W'(131069);
      8:       val = Z_W'(65536);
      9:       val = Z_W'(32768);
      10:      val = Z_W'(16384);
      11:      val = Z_W'(8192);
      12:      val = Z_W'(4096);
      13:      val = Z_W'(2048);
      14:      val = Z_W'(1024);
      15:      val = Z_W'(512);
      16:      val = Z_W'(256);
      17:      val = Z_W'(128);
      18:      val = Z_W'(64);
      19:      val = Z_W'(32);
      20:      val = Z_W'(16);
      21:      val = Z_W'(8);
      22:      val = Z_W'(4);
      23:      val = Z_W'(2);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== sv/c2p_cordic.sv =====
// Unrolled first-quadrant CORDIC in vectoring mode, one iteration per pipeline stage.
module c2p_cordic (
  input  logic                                 clk,
  input  logic [c2p_pkg::PIPE_DEPTH-1:0]       en,
  input  logic [c2p_pkg::MAG_W-1:0]            ax,
  input  logic [c2p_pkg::MAG_W-1:0]            ay,
  output logic signed [c2p_pkg::Z_W-1:0]       angle_acc
);

  localparam int N    = c2p_pkg::CORDIC_STAGES;
  localparam int XY_W = c2p_pkg::XY_W;
  localparam int Z_W  = c2p_pkg::Z_W;

  // The last iteration only needs to produce the angle accumulator.
  logic signed [XY_W-1:0] x_r [N-1];
  logic signed [XY_W-1:0] y_r [N-1];
  logic signed [Z_W-1:0]  z_r [N];

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [XY_W-1:0] x_in;
    logic signed [XY_W-1:0] y_in;
    logic signed [Z_W-1:0]  z_in;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic                   y_pos;

    if (i == 0) begin : g_first
      assign x_in = signed'({3'b000, ax, {c2p_pkg::CORDIC_FRAC{1'b0}}});
      assign y_in = signed'({3'b000, ay, {c2p_pkg::CORDIC_FRAC{1'b0}}});
      assign z_in = '0;
    end else begin : g_rest
      assign x_in = x_r[i-1];
      assign y_in = y_r[i-1];
      assign z_in = z_r[i-1];
    end

    assign xs    = x_in >>> i;
    assign ys    = y_in >>> i;
    assign y_pos = !y_in[XY_W-1];

    always_ff @(posedge clk) begin
      if (en[c2p_pkg::S_PREP+1+i]) begin
        z_r[i] <= y_pos ? (z_in + c2p_pkg::atan_q24(i)) : (z_in - c2p_pkg::atan_q24(i));
      end
    end

    if (i < N - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (en[c2p_pkg::S_PREP+1+i]) begin
          x_r[i] <= y_pos ? (x_in + ys) : (x_in - ys);
          y_r[i] <= y_pos ? (y_in - xs) : (y_in + xs);
        end
      end
    end
  end

  assign angle_acc = z_r[N-1];

endmodule

// ===== sv/c2p_sqrt.sv =====
// Pipelined distance path: squares, sum, then one root bit per stage.
module c2p_sqrt (
  input  logic                              clk,
  input  logic [c2p_pkg::PIPE_DEPTH-1:0]    en,
  input  logic [c2p_pkg::MAG_W-1:0]         ax,
  input  logic [c2p_pkg::MAG_W-1:0]         ay,
  output logic [c2p_pkg::ROOT_W-1:0]        root
);

  localparam int MAG_W     = c2p_pkg::MAG_W;
  localparam int ROOT_W    = c2p_pkg::ROOT_W;
  localparam int REM_W     = c2p_pkg::REM_W;
  localparam int RAD_PAD_W = c2p_pkg::RAD_PAD_W;

  logic [2*MAG_W-1:0]     sq_x_r;
  logic [2*MAG_W-1:0]     sq_y_r;
  logic [RAD_PAD_W-1:0]   rad_sum_r;

  always_ff @(posedge clk) begin
    if (en[c2p_pkg::S_SQR]) begin
      sq_x_r <= (2*MAG_W)'(ax) * (2*MAG_W)'(ax);
      sq_y_r <= (2*MAG_W)'(ay) * (2*MAG_W)'(ay);
    end
  end

  // Radicand is (dx^2 + dy^2) scaled by 256, so the root comes out in Q.4.
  always_ff @(posedge clk) begin
    if (en[c2p_pkg::S_SUM]) begin
      rad_sum_r <= RAD_PAD_W'({({1'b0, sq_x_r} + {1'b0, sq_y_r}), 8'h00});
    end
  end

  logic [RAD_PAD_W-1:0] rad_r  [ROOT_W-1];
  logic [REM_W-1:0]     rem_r  [ROOT_W-1];
  logic [ROOT_W-1:0]    root_r [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_digit
    logic [RAD_PAD_W-1:0] rad_in;
    logic [REM_W-1:0]     rem_in;
    logic [ROOT_W-1:0]    root_in;
    logic [REM_W-1:0]     rem_sh;
    logic [REM_W-1:0]     trial;
    logic                 take;

    if (j == 0) begin : g_first
      assign rad_in  = rad_sum_r;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_rest
      assign rad_in  = rad_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_PAD_W-1-2*j -: 2]};
    assign trial  = REM_W'({root_in, 2'b01});
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en[c2p_pkg::S_SUM+1+j]) begin
        root_r[j] <= {root_in[ROOT_W-2:0], take};
      end
    end

    if (j < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[c2p_pkg::S_SUM+1+j]) begin
          rad_r[j] <= rad_in;
          rem_r[j] <= take ? (rem_sh - trial) : rem_sh;
        end
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

// ===== sv/cartesian_to_polar_unit.sv =====
// Top level of the pointer position to polar (angle, distance) converter.
//
//   channel | direction | ports
//   --------+-----------+------------------------------------------------------
//   cfg     | in        | cfg_we, cfg_index, cfg_wdata (write only)
//   in      | in        | in_valid, in_stall, in_point_x, in_point_y
//   out     | out       | out_valid, out_stall, out_angle, out_distance
//
// One item enters per cycle while in_stall is low; new items enter before earlier ones leave.
// The depth is set by the square root path: one prep stage, one multiply stage,
// one sum stage and one stage per root bit (17); the 16 CORDIC stages fit inside.
// Reset (synchronous, rst_n low) empties the pipeline and loads the registers' defaults.
// A stall on the output freezes only stages with no empty stage at or after them.
module cartesian_to_polar_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,

  input  logic                                   cfg_we,
  input  logic [c2p_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [c2p_pkg::CFG_W-1:0]              cfg_wdata,

  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [c2p_pkg::COORD_BITS-1:0]  in_point_x,
  input  logic signed [c2p_pkg::COORD_BITS-1:0]  in_point_y,

  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [c2p_pkg::ANG_W-1:0]       out_angle,
  output logic [c2p_pkg::DIST_W-1:0]             out_distance
);

  localparam int D       = c2p_pkg::PIPE_DEPTH;
  localparam int S_ANG   = c2p_pkg::S_ANG;
  localparam int DELTA_W = c2p_pkg::DELTA_W;
  localparam int MAG_W   = c2p_pkg::MAG_W;
  localparam int ANG_W   = c2p_pkg::ANG_W;
  localparam int Z_W     = c2p_pkg::Z_W;
  localparam int ROOT_W  = c2p_pkg::ROOT_W;
  localparam int DIST_W  = c2p_pkg::DIST_W;
  localparam int CMP_W   = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;

  typedef struct packed {
    logic zx;
    logic zy;
    logic dx_pos;
    logic dx_neg;
    logic dy_pos;
    logic dy_neg;
  } quad_t;

  // Configuration registers.
  logic [c2p_pkg::CENTER_W-1:0] center_x_r;
  logic [c2p_pkg::CENTER_W-1:0] center_y_r;
  logic [c2p_pkg::DZ_W-1:0]     dead_zone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= c2p_pkg::CENTER_W'(250);
      center_y_r  <= c2p_pkg::CENTER_W'(250);
      dead_zone_r <= c2p_pkg::DZ_W'(1);
    end else if (cfg_we) begin
      case (c2p_pkg::cfg_reg_t'(cfg_index))
        c2p_pkg::REG_CENTER_X:  center_x_r  <= cfg_wdata[c2p_pkg::CENTER_W-1:0];
        c2p_pkg::REG_CENTER_Y:  center_y_r  <= cfg_wdata[c2p_pkg::CENTER_W-1:0];
        c2p_pkg::REG_DEAD_ZONE: dead_zone_r <= cfg_wdata[c2p_pkg::DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage k loads when it is empty or when the next stage can move.
  logic [D-1:0] valid_r;
  logic [D-1:0] en;

  for (genvar k = 0; k < D; k++) begin : g_en
    assign en[k] = !out_stall || !(&valid_r[D-1:k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < D; k++) begin
        if (en[k]) begin
          valid_r[k] <= (k == 0) ? in_valid : valid_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = valid_r[D-1];

  // Prep stage: offsets, magnitudes and quadrant flags.
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic [MAG_W-1:0]          ax;
  logic [MAG_W-1:0]          ay;
  quad_t                     quad_nxt;

  assign dx = DELTA_W'(in_point_x) - signed'(DELTA_W'(center_x_r));
  assign dy = DELTA_W'(in_point_y) - signed'(DELTA_W'(center_y_r));
  assign ax = dx[DELTA_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
  assign ay = dy[DELTA_W-1] ? MAG_W'(-dy) : MAG_W'(dy);

  always_comb begin
    quad_nxt.zx     = (ax < MAG_W'(dead_zone_r));
    quad_nxt.zy     = (ay < MAG_W'(dead_zone_r));
    quad_nxt.dx_neg = dx[DELTA_W-1];
    quad_nxt.dy_neg = dy[DELTA_W-1];
    quad_nxt.dx_pos = !dx[DELTA_W-1] && (dx != '0);
    quad_nxt.dy_pos = !dy[DELTA_W-1] && (dy != '0);
  end

  logic [MAG_W-1:0] ax_r;
  logic [MAG_W-1:0] ay_r;
  quad_t            quad_r [S_ANG];

  always_ff @(posedge clk) begin
    if (en[c2p_pkg::S_PREP]) begin
      ax_r                    <= ax;
      ay_r                    <= ay;
      quad_r[c2p_pkg::S_PREP] <= quad_nxt;
    end
  end

  for (genvar k = c2p_pkg::S_PREP + 1; k < S_ANG; k++) begin : g_quad
    always_ff @(posedge clk) begin
      if (en[k]) begin
        quad_r[k] <= quad_r[k-1];
      end
    end
  end

  logic signed [Z_W-1:0] angle_acc;

  c2p_cordic u_cordic (
    .clk       (clk),
    .en        (en),
    .ax        (ax_r),
    .ay        (ay_r),
    .angle_acc (angle_acc)
  );

  logic [ROOT_W-1:0] root;

  c2p_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .ax   (ax_r),
    .ay   (ay_r),
    .root (root)
  );

  // Angle stage: round the Q.24 accumulator to Q.12, clamp, then unfold the quadrant.
  logic signed [Z_W-1:0]   z_round;
  logic signed [ANG_W-1:0] t_q1;
  logic signed [ANG_W-1:0] ang_nxt;
  quad_t                   q;

  assign q       = quad_r[S_ANG-1];
  assign z_round = (angle_acc + Z_W'(c2p_pkg::ROUND_BIAS)) >>> c2p_pkg::ANG_SHIFT;

  always_comb begin
    if (z_round[Z_W-1]) begin
      t_q1 = '0;
    end else if (z_round > Z_W'(c2p_pkg::ANG_HALF_PI)) begin
      t_q1 = c2p_pkg::ANG_HALF_PI;
    end else begin
      t_q1 = z_round[ANG_W-1:0];
    end

    if (q.zx && q.zy) begin
      ang_nxt = '0;
    end else if (q.zx) begin
      ang_nxt = q.dy_neg ? -c2p_pkg::ANG_HALF_PI : c2p_pkg::ANG_HALF_PI;
    end else if (q.zy) begin
      ang_nxt = q.dx_neg ? c2p_pkg::ANG_PI : '0;
    end else if (q.dx_pos) begin
      ang_nxt = q.dy_pos ? t_q1 : -t_q1;
    end else begin
      ang_nxt = q.dy_pos ? (c2p_pkg::ANG_PI - t_q1) : (t_q1 - c2p_pkg::ANG_PI);
    end
  end

  logic signed [ANG_W-1:0] ang_r [S_ANG:D-1];

  always_ff @(posedge clk) begin
    if (en[S_ANG]) begin
      ang_r[S_ANG] <= ang_nxt;
    end
  end

  for (genvar k = S_ANG + 1; k < D; k++) begin : g_ang
    always_ff @(posedge clk) begin
      if (en[k]) begin
        ang_r[k] <= ang_r[k-1];
      end
    end
  end

  assign out_angle = ang_r[D-1];

  // The distance field saturates at its all-ones value.
  logic [CMP_W-1:0]  root_ext;
  logic [DIST_W-1:0] dist_sat;

  assign root_ext = CMP_W'(root);
  assign dist_sat = (root_ext > CMP_W'(c2p_pkg::DIST_MAX)) ? c2p_pkg::DIST_MAX
                                                           : DIST_W'(root_ext);

  if (c2p_pkg::SQRT_LAST == D - 1) begin : g_dist_direct
    assign out_distance = dist_sat;
  end else begin : g_dist_delay
    logic [DIST_W-1:0] dist_r [c2p_pkg::SQRT_LAST+1:D-1];

    always_ff @(posedge clk) begin
      if (en[c2p_pkg::SQRT_LAST+1]) begin
        dist_r[c2p_pkg::SQRT_LAST+1] <= dist_sat;
      end
    end

    for (genvar k = c2p_pkg::SQRT_LAST + 2; k < D; k++) begin : g_dd
      always_ff @(posedge clk) begin
        if (en[k]) begin
          dist_r[k] <= dist_r[k-1];
        end
      end
    end

    assign out_distance = dist_r[D-1];
  end

endmodule

// ===== sv/c2p_checker.sv =====
// Port-level checker for the polar conversion block and its bind statement.
`include "cartesian_to_polar_unit_defines.svh"

module c2p_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   cfg_we,
  input logic [c2p_pkg::CFG_IDX_W-1:0]          cfg_index,
  input logic [c2p_pkg::CFG_W-1:0]              cfg_wdata,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic signed [c2p_pkg::COORD_BITS-1:0]  in_point_x,
  input logic signed [c2p_pkg::COORD_BITS-1:0]  in_point_y,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [c2p_pkg::ANG_W-1:0]       out_angle,
  input logic [c2p_pkg::DIST_W-1:0]             out_distance
);

  // A waiting result stays put until it is taken.
  `C2P_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_angle) && $stable(out_distance))

  // With the output side free to move, the pipeline always has room for an item.
  `C2P_ASSERT_IMP(a_in_open, !(out_valid && out_stall), !in_stall)

  // Every angle lies within minus pi to pi.
  `C2P_ASSERT_IMP(a_angle_range, out_valid, (out_angle <= c2p_pkg::ANG_PI) && (out_angle >= c2p_pkg::ANG_NEG_PI))

  // Reset empties the pipeline.
  `C2P_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind cartesian_to_polar_unit c2p_checker u_c2p_checker (.*);
